/* hw/rtl/lqs_pkg.sv */
package lqs_pkg;

    // Field widths of the block's words.
    localparam int ADDR_W    = 16;
    localparam int RND_W     = 16;
    localparam int COUNT_W   = 8;
    localparam int WEIGHT_W  = 9;
    localparam int SLOT_W    = 2;
    localparam int CFG_IDX_W = 3;

    // A running weight sum covers up to thirty-one slots of weight 1.0.
    localparam int WSUM_W = 13;

    // Weight 1.0 in unsigned Q1.8.
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

    // Only the first few slots have a weight register.
    localparam int NUM_WEIGHT_REGS = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0     = 3'd1;

    // Input word kinds.
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Pass that a token performs as it walks the cell chain.
    typedef enum logic
    {
        MODE_SCAN,
        MODE_PICK
    } tok_mode_t;

    // Token handed from cell to cell, one cell per cycle.
    typedef struct packed
    {
        logic                valid;
        tok_mode_t           mode;
        logic                found;
        logic                free;
        logic [WSUM_W-1:0]   sum;
        logic [ADDR_W-1:0]   addr;
    } lqs_tok_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed
    {
        logic [ADDR_W-1:0]   addr;
        logic [WSUM_W-1:0]   r;
        logic                inc_sel;
        logic                bind_free;
        logic                dec_sel;
    } lqs_cmd_t;

    // Result word, accepted in the lowest bit.
    typedef struct packed
    {
        logic [ADDR_W-1:0]   granted_addr;
        logic [SLOT_W-1:0]   granted_slot;
        logic                granted;
        logic                table_full;
        logic                accepted;
    } lqs_res_t;

endpackage

/* hw/rtl/lqs_cell.sv */
module lqs_cell
    import lqs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  lqs_tok_t            tok_in,
    input  lqs_cmd_t            cmd,
    input  logic [WEIGHT_W-1:0] weight,
    output lqs_tok_t            tok_out,
    output logic                sel
);

    logic                used_reg, used_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                sel_reg, sel_next;
    logic                free_reg, free_next;
    lqs_tok_t            tok_reg, tok_next;

    logic [WEIGHT_W-1:0] w_eff;
    logic [WSUM_W-1:0]   sum_next;
    logic                match;
    logic                take;

    // An empty slot takes no part in the lottery.
    assign w_eff    = (count_reg != '0) ? weight : '0;
    assign sum_next = tok_in.sum + WSUM_W'(w_eff);
    assign match    = used_reg && (addr_reg == cmd.addr);
    assign take     = used_reg && !tok_in.found && (sum_next > cmd.r);

    // Token pass: update the carried flags and latch this slot's role.
    always_comb
    begin
        tok_next     = tok_in;
        tok_next.sum = sum_next;
        sel_next     = sel_reg;
        free_next    = free_reg;
        if (tok_in.valid)
        begin
            case (tok_in.mode)
                MODE_SCAN:
                begin
                    sel_next       = match && !tok_in.found;
                    free_next      = !used_reg && !tok_in.free;
                    tok_next.found = tok_in.found || match;
                    tok_next.free  = tok_in.free || !used_reg;
                end
                MODE_PICK:
                begin
                    sel_next       = take;
                    tok_next.found = tok_in.found || take;
                    if (take)
                    begin
                        tok_next.addr = addr_reg;
                    end
                end
                default:
                begin
                    sel_next = sel_reg;
                end
            endcase
        end
    end

    // Slot update on the controller's broadcast.
    always_comb
    begin
        used_next  = used_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        if (cmd.inc_sel && sel_reg)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.bind_free && free_reg)
        begin
            used_next  = 1'b1;
            addr_next  = cmd.addr;
            count_next = count_reg + 1'b1;
        end
        if (cmd.dec_sel && sel_reg)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            count_reg <= '0;
            sel_reg   <= 1'b0;
            free_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            count_reg <= count_next;
            sel_reg   <= sel_next;
            free_reg  <= free_next;
            tok_reg   <= tok_next;
        end
    end

    // The bound address is read only once the slot is in use.
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

    assign tok_out = tok_reg;
    assign sel     = sel_reg;

endmodule

/* hw/rtl/lqs_ctrl.sv */
module lqs_ctrl
    import lqs_pkg::*;
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output lqs_res_t             m_res,
    input  logic [COUNT_W-1:0]   queue_limit,
    output lqs_tok_t             tok_first,
    input  lqs_tok_t             tok_last,
    input  logic [NUM_SLOTS-1:0] sel,
    output lqs_cmd_t             cmd
);

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int PROD_W = RND_W + WSUM_W;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_MULT,
        ST_PICK,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                func_reg, func_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [RND_W-1:0]    rnd_reg, rnd_next;
    logic [WSUM_W-1:0]   wsum_reg, wsum_next;
    logic [WSUM_W-1:0]   r_reg, r_next;
    logic [COUNT_W-1:0]  total_reg, total_next;
    lqs_res_t            res_reg, res_next;
    lqs_res_t            out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    lqs_tok_t            inj_reg, inj_next;

    logic [PROD_W-1:0]   prod;
    logic [IDX_W-1:0]    idx;
    logic [IDX_W+1:0]    idx_ext;

    // Scaled draw: floor(rand_value * W / 65536).
    assign prod = PROD_W'(rnd_reg) * PROD_W'(wsum_reg);

    // Slot index of the single cell that won the draw.
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (sel[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
    end

    assign idx_ext = (IDX_W + 2)'(idx);

    // Sequencer for one word: limit or empty check, scan pass, then for a dequeue the draw and pick pass.
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        addr_next      = addr_reg;
        rnd_next       = rnd_reg;
        wsum_next      = wsum_reg;
        r_next         = r_reg;
        total_next     = total_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        inj_next       = '0;
        cmd            = '0;
        cmd.addr       = addr_reg;
        cmd.r          = r_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next = s_tuser;
                    addr_next = s_tdata[ADDR_W-1:0];
                    rnd_next  = s_tdata[ADDR_W+RND_W-1:ADDR_W];
                    res_next  = '0;
                    if ((s_tuser == FUNC_ENQ) && (total_reg >= queue_limit))
                    begin
                        state_next = ST_DONE;
                    end
                    else if ((s_tuser == FUNC_DEQ) && (total_reg == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        inj_next.valid = 1'b1;
                        inj_next.mode  = MODE_SCAN;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (tok_last.valid)
                begin
                    res_next = '0;
                    if (func_reg == FUNC_ENQ)
                    begin
                        state_next = ST_DONE;
                        if (tok_last.found)
                        begin
                            cmd.inc_sel       = 1'b1;
                            res_next.accepted = 1'b1;
                            total_next        = total_reg + 1'b1;
                        end
                        else if (tok_last.free)
                        begin
                            cmd.bind_free     = 1'b1;
                            res_next.accepted = 1'b1;
                            total_next        = total_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.table_full = 1'b1;
                        end
                    end
                    else if (tok_last.sum == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        wsum_next  = tok_last.sum;
                        state_next = ST_MULT;
                    end
                end
            end
            ST_MULT:
            begin
                r_next         = prod[PROD_W-1:RND_W];
                inj_next.valid = 1'b1;
                inj_next.mode  = MODE_PICK;
                state_next     = ST_PICK;
            end
            ST_PICK:
            begin
                if (tok_last.valid)
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                    if (tok_last.found)
                    begin
                        cmd.dec_sel           = 1'b1;
                        total_next            = total_reg - 1'b1;
                        res_next.granted      = 1'b1;
                        res_next.granted_slot = idx_ext[SLOT_W-1:0];
                        res_next.granted_addr = tok_last.addr;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            func_reg      <= FUNC_ENQ;
            addr_reg      <= '0;
            rnd_reg       <= '0;
            wsum_reg      <= '0;
            r_reg         <= '0;
            total_reg     <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            inj_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            addr_reg      <= addr_next;
            rnd_reg       <= rnd_next;
            wsum_reg      <= wsum_next;
            r_reg         <= r_next;
            total_reg     <= total_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            inj_reg       <= inj_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_res     = out_reg;
    assign tok_first = inj_reg;

endmodule

/* hw/rtl/lottery_queue_scheduler.sv */
// Paths to m_tvalid: an enqueue at the limit or a dequeue with nothing queued goes straight to the result,
// any other enqueue or a dequeue whose queued slots weigh zero takes the scan pass through every cell,
// and any other dequeue also takes the draw and then the pick pass through every cell.
// One word is in work at a time and the next is taken only once the result is loaded into the
// output register; a held result stalls.
// Reset (rst_n low, asynchronous) unbinds all slots, clears all counts and restores the registers.
module lottery_queue_scheduler
    import lqs_pkg::*;
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // dest_addr[15:0], rand_value[31:16]
    input  logic                 s_tuser,   // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // accepted[0], table_full[1], granted[2],
                                            // granted_slot[4:3], granted_addr[20:5]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WEIGHT_W-1:0]  cfg_data
);

    logic [COUNT_W-1:0]  queue_limit_reg;
    logic [WEIGHT_W-1:0] weight_reg [NUM_WEIGHT_REGS];
    logic [WEIGHT_W-1:0] wclamp;

    lqs_tok_t            tok [NUM_SLOTS+1];
    lqs_cmd_t            cmd;
    logic [NUM_SLOTS-1:0] sel;
    lqs_res_t            res;

    // Weights above 1.0 are held at 1.0.
    assign wclamp = (cfg_data > WEIGHT_ONE) ? WEIGHT_ONE : cfg_data;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_limit_reg <= 8'd50;
            for (int i = 0; i < NUM_WEIGHT_REGS; i++)
            begin
                weight_reg[i] <= WEIGHT_ONE;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_QUEUE_LIMIT)
            begin
                queue_limit_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < NUM_WEIGHT_REGS; i++)
            begin
                if (cfg_index == REG_WEIGHT0 + CFG_IDX_W'(i))
                begin
                    weight_reg[i] <= wclamp;
                end
            end
        end
    end

    lqs_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_res       (res),
        .queue_limit (queue_limit_reg),
        .tok_first   (tok[0]),
        .tok_last    (tok[NUM_SLOTS]),
        .sel         (sel),
        .cmd         (cmd)
    );

    // Chain of slot cells; slots past the weight registers weigh 1.0.
    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        logic [WEIGHT_W-1:0] w;

        if (g < NUM_WEIGHT_REGS)
        begin : g_wreg
            assign w = weight_reg[g];
        end
        else
        begin : g_wone
            assign w = WEIGHT_ONE;
        end

        lqs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[g]),
            .cmd     (cmd),
            .weight  (w),
            .tok_out (tok[g+1]),
            .sel     (sel[g])
        );
    end

    assign m_tdata = {3'b000, res};

endmodule

/* verif/tb_lottery_queue_scheduler.sv */
`timescale 1ns / 1ps

module tb_lottery_queue_scheduler;
    import lqs_pkg::*;

    localparam int SLOTS        = 4;
    localparam int TARGET_WORDS = 1950;
    localparam int QUIET_FROM   = 1700;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int WIDX_W       = $clog2(NUM_WEIGHT_REGS);

    // Index range that no register answers to.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST =
        REG_WEIGHT0 + CFG_IDX_W'(NUM_WEIGHT_REGS);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

    typedef enum logic
    {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    // One line of the directed table: an input word or a register write.
    typedef struct
    {
        row_kind_t             kind;
        logic                  func;
        logic [ADDR_W-1:0]     addr;
        logic [RND_W-1:0]      rnd;
        logic [CFG_IDX_W-1:0]  idx;
        logic [WEIGHT_W-1:0]   data;
        logic                  fixed;
        lqs_res_t              res;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // dest_addr[15:0], rand_value[31:16]
    logic                  s_tuser;   // func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // accepted[0], table_full[1], granted[2],
                                      // granted_slot[4:3], granted_addr[20:5]
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [WEIGHT_W-1:0]   cfg_data;

    // Shadow of the scheduler's configuration and slot table.
    logic [COUNT_W-1:0]    limit_reg;
    logic [WEIGHT_W-1:0]   weight_reg [NUM_WEIGHT_REGS];
    logic [ADDR_W-1:0]     slot_addr  [SLOTS];
    logic                  slot_used  [SLOTS];
    logic [COUNT_W-1:0]    slot_cnt   [SLOTS];
    logic [COUNT_W-1:0]    total_cnt;

    lqs_res_t              pending_results [$];
    dir_row_t              dir_rows [$];
    int                    err_cnt = 0;
    int                    words_sent;
    int                    cycle_cnt = 0;
    logic                  idle_on;
    logic                  hold_req;
    lqs_res_t              got_res;
    lqs_res_t              want_res;

    lottery_queue_scheduler #(
        .NUM_SLOTS (SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Work out the result of one word and advance the shadow table.
    function automatic lqs_res_t schedule_word(input logic func,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [RND_W-1:0] rnd);
        lqs_res_t res;
        int hit;
        int free_slot;
        int wsum;
        int run;
        int draw;
        res = '0;
        hit = -1;
        free_slot = -1;
        wsum = 0;
        run = 0;
        if (func == FUNC_ENQ)
        begin
            if (total_cnt >= limit_reg)
                return res;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_used[i] && slot_addr[i] == addr && hit < 0)
                    hit = i;
                if (!slot_used[i] && free_slot < 0)
                    free_slot = i;
            end
            if (hit < 0)
            begin
                if (free_slot < 0)
                begin
                    res.table_full = 1'b1;
                    return res;
                end
                hit = free_slot;
                slot_used[hit] = 1'b1;
                slot_addr[hit] = addr;
            end
            slot_cnt[hit] = slot_cnt[hit] + 1'b1;
            total_cnt = total_cnt + 1'b1;
            res.accepted = 1'b1;
            return res;
        end
        if (total_cnt == 0)
            return res;
        // Only slots that hold packets take part in the draw.
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_cnt[i] != 0)
                wsum += weight_reg[i];
        if (wsum == 0)
            return res;
        draw = int'((32'(rnd) * 32'(wsum)) >> 16);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_used[i] && slot_cnt[i] != 0)
            begin
                run += weight_reg[i];
                if (run > draw)
                begin
                    slot_cnt[i] = slot_cnt[i] - 1'b1;
                    total_cnt = total_cnt - 1'b1;
                    res.granted = 1'b1;
                    res.granted_slot = i[SLOT_W-1:0];
                    res.granted_addr = slot_addr[i];
                    return res;
                end
            end
        end
        return res;
    endfunction

    function automatic lqs_res_t res_of(input logic acc, input logic full, input logic gr,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [ADDR_W-1:0] addr);
        lqs_res_t res;
        res.accepted = acc;
        res.table_full = full;
        res.granted = gr;
        res.granted_slot = slot;
        res.granted_addr = addr;
        return res;
    endfunction

    function automatic dir_row_t word_row(input logic func, input logic [ADDR_W-1:0] addr,
                                          input logic [RND_W-1:0] rnd, input logic fixed,
                                          input lqs_res_t res);
        dir_row_t row;
        row.kind = ROW_WORD;
        row.func = func;
        row.addr = addr;
        row.rnd = rnd;
        row.idx = '0;
        row.data = '0;
        row.fixed = fixed;
        row.res = res;
        return row;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [WEIGHT_W-1:0] data);
        dir_row_t row;
        row = word_row(FUNC_ENQ, '0, '0, 1'b0, '0);
        row.kind = ROW_REG;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    // Offer one word, wait for the handshake, and queue its expected result.
    task automatic send_word(input logic func, input logic [ADDR_W-1:0] addr,
                             input logic [RND_W-1:0] rnd, input logic fixed,
                             input lqs_res_t fixed_res);
        lqs_res_t want;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {rnd, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = schedule_word(func, addr, rnd);
        if (fixed)
            want = fixed_res;
        pending_results.push_back(want);
        words_sent++;
        @(negedge clk);
    endtask

    // Stop offering and let every outstanding result come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        cfg_we <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        if (idx == REG_QUEUE_LIMIT)
            limit_reg = val[COUNT_W-1:0];
        else if (idx >= REG_WEIGHT0 && idx < REG_UNUSED_FIRST)
            weight_reg[WIDX_W'(idx - REG_WEIGHT0)] = (val > WEIGHT_ONE) ? WEIGHT_ONE : val;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Receiver: random short stalls, and one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every result word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = m_tdata[$bits(lqs_res_t)-1:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result word %h with nothing expected", $time, m_tdata);
                err_cnt++;
            end
            else
            begin
                want_res = pending_results.pop_front();
                check_field("accepted", want_res.accepted, got_res.accepted);
                check_field("table_full", want_res.table_full, got_res.table_full);
                check_field("granted", want_res.granted, got_res.granted);
                check_field("granted_slot", want_res.granted_slot, got_res.granted_slot);
                check_field("granted_addr", want_res.granted_addr, got_res.granted_addr);
                check_field("padding", 0, m_tdata[23:$bits(lqs_res_t)]);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t ns: run did not finish in time", $time);
            $display("** lottery_queue_scheduler: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int deq_pct;
        int n_words;
        int pick;
        logic func;
        logic [ADDR_W-1:0] addr;
        logic [RND_W-1:0] rnd;
        logic [WEIGHT_W-1:0] w;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = FUNC_ENQ;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        words_sent = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;

        // Shadow starts from the reset state of the block.
        limit_reg = 8'd50;
        total_cnt = '0;
        for (int i = 0; i < NUM_WEIGHT_REGS; i++)
            weight_reg[i] = WEIGHT_ONE;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_addr[i] = '0;
            slot_used[i] = 1'b0;
            slot_cnt[i] = '0;
        end

        // Directed table, starting from the reset settings.
        dir_rows.push_back(word_row(FUNC_DEQ, 16'hFFFF, 16'hFFFF, 1'b1, '0));
        dir_rows.push_back(word_row(FUNC_ENQ, 16'h0000, 16'hFFFF, 1'b1,
                                    res_of(1, 0, 0, 0, 0)));
        dir_rows.push_back(word_row(FUNC_ENQ, 16'hFFFF, 16'h0000, 1'b1,
                                    res_of(1, 0, 0, 0, 0)));
        dir_rows.push_back(word_row(FUNC_ENQ, 16'h1234, 16'h0000, 1'b1,
                                    res_of(1, 0, 0, 0, 0)));
        dir_rows.push_back(word_row(FUNC_ENQ, 16'hABCD, 16'h0000, 1'b1,
                                    res_of(1, 0, 0, 0, 0)));
        // A fifth address finds every slot bound.
        dir_rows.push_back(word_row(FUNC_ENQ, 16'h5555, 16'h0000, 1'b1,
                                    res_of(0, 1, 0, 0, 0)));
        dir_rows.push_back(word_row(FUNC_ENQ, 16'hFFFF, 16'h0000, 1'b1,
                                    res_of(1, 0, 0, 0, 0)));
        dir_rows.push_back(word_row(FUNC_DEQ, 16'h0000, 16'h0000, 1'b1,
                                    res_of(0, 0, 1, 0, 16'h0000)));
        dir_rows.push_back(word_row(FUNC_DEQ, 16'h0000, 16'hFFFF, 1'b1,
                                    res_of(0, 0, 1, 3, 16'hABCD)));
        dir_rows.push_back(word_row(FUNC_DEQ, 16'h0000, 16'h0000, 1'b0, '0));
        // Drained slots stay bound, so the new address is still refused.
        dir_rows.push_back(word_row(FUNC_ENQ, 16'h5555, 16'h0000, 1'b1,
                                    res_of(0, 1, 0, 0, 0)));
        dir_rows.push_back(word_row(FUNC_ENQ, 16'h0000, 16'h0000, 1'b0, '0));
        // Limit reached drops without the table-full flag.
        dir_rows.push_back(reg_row(REG_QUEUE_LIMIT, 9'd3));
        dir_rows.push_back(word_row(FUNC_ENQ, 16'h1234, 16'h0000, 1'b1, '0));
        dir_rows.push_back(word_row(FUNC_ENQ, 16'h9999, 16'h0000, 1'b1, '0));
        dir_rows.push_back(reg_row(REG_QUEUE_LIMIT, 9'd0));
        dir_rows.push_back(word_row(FUNC_ENQ, 16'h0000, 16'h0000, 1'b1, '0));
        // All weights zero: nothing is granted.
        for (int i = 0; i < NUM_WEIGHT_REGS; i++)
            dir_rows.push_back(reg_row(REG_WEIGHT0 + CFG_IDX_W'(i), 9'd0));
        dir_rows.push_back(word_row(FUNC_DEQ, 16'h0000, 16'h8000, 1'b1, '0));
        // An oversized weight clamps to 1.0; an unused index is ignored.
        dir_rows.push_back(reg_row(REG_WEIGHT0 + 3'd2, 9'h1FF));
        dir_rows.push_back(reg_row(REG_UNUSED_LAST, 9'h1FF));
        dir_rows.push_back(word_row(FUNC_DEQ, 16'h0000, 16'hFFFF, 1'b1,
                                    res_of(0, 0, 1, 2, 16'h1234)));
        dir_rows.push_back(reg_row(REG_QUEUE_LIMIT, 9'h1FF));
        dir_rows.push_back(word_row(FUNC_ENQ, 16'h1234, 16'hFFFF, 1'b0, '0));

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                cfg_we <= 1'b0;
                send_word(dir_rows[i].func, dir_rows[i].addr, dir_rows[i].rnd,
                          dir_rows[i].fixed, dir_rows[i].res);
            end
        end

        // Random phases, each with its own limit, weights and traffic mix.
        phase = 0;
        while (words_sent < TARGET_WORDS)
        begin
            wait_idle();
            if (words_sent >= QUIET_FROM)
                idle_on = 1'b0;
            case ($urandom_range(0, 5))
                0: w = 9'd0;
                1: w = 9'd1;
                2: w = 9'd255;
                3: w = WEIGHT_W'($urandom_range(2, 12));
                4: w = WEIGHT_W'($urandom_range(13, 60));
                default: w = WEIGHT_W'($urandom_range(0, 511));
            endcase
            write_reg(REG_QUEUE_LIMIT, w);
            for (int i = 0; i < NUM_WEIGHT_REGS; i++)
            begin
                case ($urandom_range(0, 5))
                    0: w = 9'd0;
                    1: w = 9'd1;
                    2: w = WEIGHT_ONE;
                    3: w = 9'h1FF;
                    4: w = WEIGHT_W'($urandom_range(0, 511));
                    default: w = WEIGHT_W'($urandom_range(1, 64));
                endcase
                write_reg(REG_WEIGHT0 + CFG_IDX_W'(i), w);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                          WEIGHT_W'($urandom_range(0, 511)));
            cfg_we <= 1'b0;

            // One phase runs against a long receiver hold-off.
            if (phase == 2)
                hold_req = 1'b1;
            deq_pct = $urandom_range(15, 75);
            n_words = $urandom_range(40, 140);
            for (int k = 0; k < n_words; k++)
            begin
                func = ($urandom_range(0, 99) < deq_pct) ? FUNC_DEQ : FUNC_ENQ;
                addr = ADDR_W'($urandom);
                rnd = RND_W'($urandom);
                if (func == FUNC_DEQ)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        rnd = '0;
                    else if (pick == 1)
                        rnd = '1;
                end
                else if ($urandom_range(0, 9) != 0)
                begin
                    // Mostly addresses that already own a slot.
                    pick = $urandom_range(0, SLOTS - 1);
                    if (slot_used[pick])
                        addr = slot_addr[pick];
                end
                send_word(func, addr, rnd, 1'b0, '0);
            end
            phase++;
        end

        wait_idle();
        repeat (SETTLE) @(negedge clk);
        if (err_cnt == 0)
            $display("** lottery_queue_scheduler: PASSED **");
        else
            $display("** lottery_queue_scheduler: FAILED **");
        $finish;
    end

endmodule

/* lottery_queue_scheduler.f */
hw/rtl/lqs_pkg.sv
hw/rtl/lqs_cell.sv
hw/rtl/lqs_ctrl.sv
hw/rtl/lottery_queue_scheduler.sv
verif/tb_lottery_queue_scheduler.sv
